>>> rtl/core/int8_mac_array_accumulate_quantize_core_assert.svh
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef INT8_MAC_ARRAY_ACCUMULATE_QUANTIZE_CORE_ASSERT_SVH
`define INT8_MAC_ARRAY_ACCUMULATE_QUANTIZE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IMAQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMAQ_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IMAQ_ASSERT(lbl, prop, msg)
`define IMAQ_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> rtl/core/imaq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imaq_pkg;

    localparam int ARRAY_ROWS = 8;
    localparam int ARRAY_COLS = 8;
    localparam int LANES      = 8;
    localparam int DEPTH      = ARRAY_ROWS * ARRAY_COLS;
    localparam int ROW_W      = (ARRAY_ROWS > 1) ? $clog2(ARRAY_ROWS) : 1;
    localparam int COL_W      = (ARRAY_COLS > 1) ? $clog2(ARRAY_COLS) : 1;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTR_W     = $clog2(ARRAY_ROWS + 1);
    localparam int CNTC_W     = $clog2(ARRAY_COLS + 1);
    localparam int MAX_SHIFT  = 23;

    localparam logic signed [24:0] ACC_MAX = 25'sd8388607;
    localparam logic signed [24:0] ACC_MIN = -25'sd8388608;
    localparam logic signed [23:0] Q_MAX   = 24'sd127;
    localparam logic signed [23:0] Q_MIN   = -24'sd128;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_MAC   = 2'd1,
        MODE_BIAS  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PHASE = 2'd1,
        ST_NOMAC = 2'd2,
        ST_SIZE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_EMPTY = 2'd0,
        PH_ACCUM = 2'd1,
        PH_FINAL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        OP_MAC  = 2'd0,
        OP_BIAS = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_BIAS,
        S_DONE,
        S_READ_ISSUE,
        S_READ_LOAD
    } state_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         rows_in_use;
        logic [3:0]         columns_in_use;
        logic [63:0]        activation_lanes;
        logic [63:0]        weight_lanes;
        logic [2:0]         bias_column;
        logic signed [23:0] bias_value;
        logic               bias_final;
        logic [4:0]         shift_amount;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [2:0]         pe_row;
        logic [2:0]         pe_column;
        logic signed [23:0] acc_value;
        logic signed [7:0]  quantized;
        logic [15:0]        slot_word;
        logic               last;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic             item_load;
        logic             clear;
        logic             issue;
        op_t              op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             emit;
        status_t          status;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
        logic out_free;
    } sts_t;

    function automatic logic signed [7:0] lane_sel(logic [63:0] lanes, int idx);
        logic signed [7:0] v;
        v = '0;
        if (idx < LANES)
        begin
            v = lanes[8*idx +: 8];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/imaq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module imaq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire imaq_pkg::in_t cmd,
    input  wire imaq_pkg::sts_t sts,
    output imaq_pkg::ctl_t     ctl
);

    imaq_pkg::state_t state_reg, state_next;
    imaq_pkg::phase_t phase_reg, phase_next;
    logic [imaq_pkg::CNTR_W-1:0] rows_reg, rows_next;
    logic [imaq_pkg::CNTC_W-1:0] cols_reg, cols_next;
    logic mac_seen_reg, mac_seen_next;
    logic final_reg, final_next;
    logic rd_last_reg, rd_last_next;
    logic [imaq_pkg::ROW_W-1:0] row_reg, row_next;
    logic [imaq_pkg::COL_W-1:0] col_reg, col_next;

    logic accept;
    logic start_bad, bias_bad, row_end, col_end;

    assign cmd_stall = (state_reg != imaq_pkg::S_IDLE) || sts.out_busy;
    assign accept    = cmd_valid && !cmd_stall;

    assign start_bad = (int'(cmd.rows_in_use) == 0) || (int'(cmd.rows_in_use) > imaq_pkg::ARRAY_ROWS)
                    || (int'(cmd.columns_in_use) == 0)
                    || (int'(cmd.columns_in_use) > imaq_pkg::ARRAY_COLS);
    assign bias_bad  = (int'(cmd.bias_column) >= int'(cols_reg))
                    || (int'(cmd.bias_column) >= imaq_pkg::ARRAY_COLS);
    assign row_end   = (int'(row_reg) == int'(rows_reg) - 1);
    assign col_end   = (int'(col_reg) == int'(cols_reg) - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            imaq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (imaq_pkg::mode_t'(cmd.mode))
                        imaq_pkg::MODE_MAC:
                            if (phase_reg == imaq_pkg::PH_ACCUM)
                                state_next = imaq_pkg::S_MAC;
                        imaq_pkg::MODE_BIAS:
                            if (phase_reg == imaq_pkg::PH_ACCUM && mac_seen_reg && !bias_bad)
                                state_next = imaq_pkg::S_BIAS;
                        imaq_pkg::MODE_READ:
                            if (phase_reg == imaq_pkg::PH_FINAL)
                                state_next = imaq_pkg::S_READ_ISSUE;
                        default:
                            state_next = imaq_pkg::S_IDLE;
                    endcase
                end
            end
            imaq_pkg::S_MAC:
                if (row_end && col_end)
                    state_next = imaq_pkg::S_DONE;
            imaq_pkg::S_BIAS:
                if (row_end)
                    state_next = imaq_pkg::S_DONE;
            imaq_pkg::S_DONE:
                state_next = imaq_pkg::S_IDLE;
            imaq_pkg::S_READ_ISSUE:
                if (sts.out_free)
                    state_next = imaq_pkg::S_READ_LOAD;
            imaq_pkg::S_READ_LOAD:
                state_next = rd_last_reg ? imaq_pkg::S_IDLE : imaq_pkg::S_READ_ISSUE;
            default:
                state_next = imaq_pkg::S_IDLE;
        endcase
    end

    // outputs and run registers
    always_comb
    begin
        ctl           = '0;
        ctl.op        = imaq_pkg::OP_MAC;
        ctl.status    = imaq_pkg::ST_OK;
        ctl.row       = row_reg;
        ctl.col       = col_reg;
        phase_next    = phase_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        mac_seen_next = mac_seen_reg;
        final_next    = final_reg;
        rd_last_next  = rd_last_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        unique case (state_reg)
            imaq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ctl.item_load = 1'b1;
                    row_next      = '0;
                    col_next      = '0;
                    unique case (imaq_pkg::mode_t'(cmd.mode))
                        imaq_pkg::MODE_START:
                        begin
                            ctl.emit = 1'b1;
                            if (start_bad)
                            begin
                                ctl.status = imaq_pkg::ST_SIZE;
                            end
                            else
                            begin
                                ctl.clear     = 1'b1;
                                rows_next     = imaq_pkg::CNTR_W'(cmd.rows_in_use);
                                cols_next     = imaq_pkg::CNTC_W'(cmd.columns_in_use);
                                mac_seen_next = 1'b0;
                                phase_next    = imaq_pkg::PH_ACCUM;
                            end
                        end
                        imaq_pkg::MODE_MAC:
                        begin
                            if (phase_reg != imaq_pkg::PH_ACCUM)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = imaq_pkg::ST_PHASE;
                            end
                            else
                            begin
                                mac_seen_next = 1'b1;
                                final_next    = 1'b0;
                            end
                        end
                        imaq_pkg::MODE_BIAS:
                        begin
                            col_next   = imaq_pkg::COL_W'(cmd.bias_column);
                            final_next = cmd.bias_final;
                            if (phase_reg != imaq_pkg::PH_ACCUM)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = imaq_pkg::ST_PHASE;
                            end
                            else if (!mac_seen_reg)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = imaq_pkg::ST_NOMAC;
                            end
                            else if (bias_bad)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = imaq_pkg::ST_SIZE;
                            end
                        end
                        default:
                        begin
                            if (phase_reg != imaq_pkg::PH_FINAL)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = imaq_pkg::ST_PHASE;
                            end
                        end
                    endcase
                end
            end
            imaq_pkg::S_MAC:
            begin
                ctl.issue = 1'b1;
                ctl.op    = imaq_pkg::OP_MAC;
                if (col_end)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            imaq_pkg::S_BIAS:
            begin
                ctl.issue = 1'b1;
                ctl.op    = imaq_pkg::OP_BIAS;
                row_next  = row_reg + 1'b1;
            end
            imaq_pkg::S_DONE:
            begin
                // last write-back lands this cycle
                ctl.emit = 1'b1;
                if (final_reg)
                begin
                    phase_next = imaq_pkg::PH_FINAL;
                    final_next = 1'b0;
                end
            end
            imaq_pkg::S_READ_ISSUE:
            begin
                if (sts.out_free)
                begin
                    ctl.issue    = 1'b1;
                    ctl.op       = imaq_pkg::OP_READ;
                    ctl.last     = row_end && col_end;
                    rd_last_next = row_end && col_end;
                    if (col_end)
                    begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            imaq_pkg::S_READ_LOAD:
            begin
                ctl.op = imaq_pkg::OP_READ;
            end
            default:
            begin
                ctl.op = imaq_pkg::OP_MAC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= imaq_pkg::S_IDLE;
            phase_reg    <= imaq_pkg::PH_EMPTY;
            rows_reg     <= '0;
            cols_reg     <= '0;
            mac_seen_reg <= 1'b0;
            final_reg    <= 1'b0;
            rd_last_reg  <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            mac_seen_reg <= mac_seen_next;
            final_reg    <= final_next;
            rd_last_reg  <= rd_last_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/imaq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
`include "int8_mac_array_accumulate_quantize_core_assert.svh"

module imaq_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire imaq_pkg::in_t  cmd,
    input  wire imaq_pkg::ctl_t ctl,
    input  wire logic           res_stall,
    output logic                res_valid,
    output imaq_pkg::out_t      res,
    output imaq_pkg::sts_t      sts
);

    // item operands, captured on the accepted transfer
    logic [63:0]        act_reg;
    logic [63:0]        wgt_reg;
    logic signed [23:0] bias_reg;
    logic [4:0]         shift_reg;

    logic signed [23:0] mem [imaq_pkg::DEPTH];
    logic [imaq_pkg::DEPTH-1:0] vld_reg, vld_next;

    logic [imaq_pkg::ADDR_W-1:0] addr;

    // read stage
    logic                        stg_vld_reg;
    imaq_pkg::op_t               stg_op_reg;
    logic [imaq_pkg::ADDR_W-1:0] stg_addr_reg;
    logic [imaq_pkg::ROW_W-1:0]  stg_row_reg;
    logic [imaq_pkg::COL_W-1:0]  stg_col_reg;
    logic                        stg_last_reg;
    logic                        stg_hit_reg;
    logic signed [7:0]           stg_a_reg;
    logic signed [7:0]           stg_w_reg;
    logic signed [23:0]          rd_data_reg;

    logic signed [23:0] acc_cur;
    logic signed [15:0] prod;
    logic signed [24:0] addend, sum;
    logic signed [23:0] sat;
    logic               wr_en;

    logic [4:0]         sh;
    logic signed [23:0] shifted;
    logic signed [7:0]  q;

    logic           out_vld_reg, out_vld_next;
    imaq_pkg::out_t out_reg, out_next;
    logic           load, pop;

    assign addr = imaq_pkg::ADDR_W'(int'(ctl.row) * imaq_pkg::ARRAY_COLS + int'(ctl.col));

    always_ff @(posedge clk)
    begin
        if (ctl.item_load)
        begin
            act_reg   <= cmd.activation_lanes;
            wgt_reg   <= cmd.weight_lanes;
            bias_reg  <= cmd.bias_value;
            shift_reg <= cmd.shift_amount;
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (ctl.clear)
        begin
            vld_next = '0;
        end
        else if (wr_en)
        begin
            vld_next[stg_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[stg_addr_reg] <= sat;
        end
        if (ctl.issue)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            stg_op_reg   <= ctl.op;
            stg_addr_reg <= addr;
            stg_row_reg  <= ctl.row;
            stg_col_reg  <= ctl.col;
            stg_last_reg <= ctl.last;
            stg_hit_reg  <= vld_reg[addr];
            stg_a_reg    <= imaq_pkg::lane_sel(act_reg, int'(ctl.row));
            stg_w_reg    <= imaq_pkg::lane_sel(wgt_reg, int'(ctl.col));
        end
    end

    // read-modify-write: never-written entries count as zero
    assign acc_cur = stg_hit_reg ? rd_data_reg : '0;
    assign prod    = stg_a_reg * stg_w_reg;
    assign addend  = (stg_op_reg == imaq_pkg::OP_MAC) ? 25'(prod) : 25'(bias_reg);
    assign sum     = 25'(acc_cur) + addend;
    assign wr_en   = stg_vld_reg && (stg_op_reg != imaq_pkg::OP_READ);

    always_comb
    begin
        if (sum > imaq_pkg::ACC_MAX)
        begin
            sat = imaq_pkg::ACC_MAX[23:0];
        end
        else if (sum < imaq_pkg::ACC_MIN)
        begin
            sat = imaq_pkg::ACC_MIN[23:0];
        end
        else
        begin
            sat = sum[23:0];
        end
    end

    // floor shift, anything past 23 behaves as 23
    assign sh      = (int'(shift_reg) > imaq_pkg::MAX_SHIFT) ? 5'(imaq_pkg::MAX_SHIFT) : shift_reg;
    assign shifted = acc_cur >>> sh;

    always_comb
    begin
        if (shifted > imaq_pkg::Q_MAX)
        begin
            q = imaq_pkg::Q_MAX[7:0];
        end
        else if (shifted < imaq_pkg::Q_MIN)
        begin
            q = imaq_pkg::Q_MIN[7:0];
        end
        else
        begin
            q = shifted[7:0];
        end
    end

    assign load = ctl.emit || (stg_vld_reg && stg_op_reg == imaq_pkg::OP_READ);
    assign pop  = out_vld_reg && !res_stall;

    always_comb
    begin
        out_next = out_reg;
        if (ctl.emit)
        begin
            out_next        = '0;
            out_next.status = ctl.status;
            out_next.last   = 1'b1;
        end
        else if (load)
        begin
            out_next.status    = imaq_pkg::ST_OK;
            out_next.pe_row    = 3'(stg_row_reg);
            out_next.pe_column = 3'(stg_col_reg);
            out_next.acc_value = acc_cur;
            out_next.quantized = q;
            out_next.slot_word = 16'(q);
            out_next.last      = stg_last_reg;
        end
        out_vld_next = load ? 1'b1 : (pop ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            stg_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            stg_vld_reg <= ctl.issue;
            out_vld_reg <= out_vld_next;
        end
    end

    assign res_valid    = out_vld_reg;
    assign res          = out_reg;
    assign sts.out_busy = out_vld_reg;
    assign sts.out_free = !out_vld_reg || !res_stall;

    `IMAQ_ASSERT_NEVER(a_load_over_full, load && out_vld_reg && res_stall, "result overwritten")
    `IMAQ_ASSERT_NEVER(a_emit_and_read, ctl.emit && stg_vld_reg && stg_op_reg == imaq_pkg::OP_READ, "two loads")
    `IMAQ_ASSERT(a_error_single, out_vld_reg && out_reg.status != imaq_pkg::ST_OK |-> out_reg.last, "error not last")

endmodule

`default_nettype wire

>>> rtl/core/int8_mac_array_accumulate_quantize_core.sv
// Start and error items: one registered result, valid in the cycle after the transfer in.
// MAC: one element per cycle over rows*columns elements; bias: each row of its column.
// Read: elements go one at a time; each is issued when the output register is free.
// The next item is taken once the previous one has delivered all its results.
// Reset (rst_n low, asynchronous) empties the run and clears all accumulators via valid bits.
`timescale 1ns / 1ps
`default_nettype none

module int8_mac_array_accumulate_quantize_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire imaq_pkg::in_t cmd,
    output logic               res_valid,
    input  wire logic          res_stall,
    output imaq_pkg::out_t     res
);

    imaq_pkg::ctl_t ctl;
    imaq_pkg::sts_t sts;

    imaq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .sts       (sts),
        .ctl       (ctl)
    );

    imaq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res       (res),
        .sts       (sts)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    class mac_array_scoreboard;
        logic signed [23:0] acc [imaq_pkg::ARRAY_ROWS][imaq_pkg::ARRAY_COLS];
        imaq_pkg::phase_t phase;
        int rows_act;
        int cols_act;
        bit mac_done;
        imaq_pkg::out_t pending [$];
        int errors;

        function new();
            errors = 0;
            phase = imaq_pkg::PH_EMPTY;
            rows_act = 0;
            cols_act = 0;
            mac_done = 0;
            foreach (acc[r, c]) acc[r][c] = '0;
        endfunction

        function logic signed [23:0] sat24(int s);
            if (s > 8388607) return 24'sd8388607;
            if (s < -8388608) return -24'sd8388608;
            return s[23:0];
        endfunction

        function logic signed [7:0] quant(logic signed [23:0] a, int sh);
            int q;
            q = int'(a) >>> sh;
            if (q > 127) q = 127;
            if (q < -128) q = -128;
            return q[7:0];
        endfunction

        function void single(imaq_pkg::status_t st);
            imaq_pkg::out_t o;
            o = '0;
            o.status = st;
            o.last = 1'b1;
            pending = {pending, o};
        endfunction

        function void note_command(imaq_pkg::in_t t);
            int a, w;
            imaq_pkg::out_t o;
            case (imaq_pkg::mode_t'(t.mode))
                imaq_pkg::MODE_START:
                begin
                    if (t.rows_in_use == 0 || t.rows_in_use > imaq_pkg::ARRAY_ROWS ||
                        t.columns_in_use == 0 || t.columns_in_use > imaq_pkg::ARRAY_COLS)
                    begin
                        single(imaq_pkg::ST_SIZE);
                    end
                    else
                    begin
                        foreach (acc[r, c]) acc[r][c] = '0;
                        rows_act = t.rows_in_use;
                        cols_act = t.columns_in_use;
                        mac_done = 0;
                        phase = imaq_pkg::PH_ACCUM;
                        single(imaq_pkg::ST_OK);
                    end
                end
                imaq_pkg::MODE_MAC:
                begin
                    if (phase != imaq_pkg::PH_ACCUM)
                    begin
                        single(imaq_pkg::ST_PHASE);
                    end
                    else
                    begin
                        for (int r = 0; r < rows_act; r++)
                        begin
                            a = $signed(t.activation_lanes[8*r +: 8]);
                            for (int c = 0; c < cols_act; c++)
                            begin
                                w = $signed(t.weight_lanes[8*c +: 8]);
                                acc[r][c] = sat24(int'(acc[r][c]) + a * w);
                            end
                        end
                        mac_done = 1;
                        single(imaq_pkg::ST_OK);
                    end
                end
                imaq_pkg::MODE_BIAS:
                begin
                    if (phase != imaq_pkg::PH_ACCUM) single(imaq_pkg::ST_PHASE);
                    else if (!mac_done) single(imaq_pkg::ST_NOMAC);
                    else if (t.bias_column >= cols_act) single(imaq_pkg::ST_SIZE);
                    else
                    begin
                        for (int r = 0; r < rows_act; r++)
                            acc[r][t.bias_column] =
                                sat24(int'(acc[r][t.bias_column]) + int'(t.bias_value));
                        if (t.bias_final) phase = imaq_pkg::PH_FINAL;
                        single(imaq_pkg::ST_OK);
                    end
                end
                default:
                begin
                    if (phase != imaq_pkg::PH_FINAL)
                    begin
                        single(imaq_pkg::ST_PHASE);
                    end
                    else
                    begin
                        for (int r = 0; r < rows_act; r++)
                            for (int c = 0; c < cols_act; c++)
                            begin
                                o = '0;
                                o.status = imaq_pkg::ST_OK;
                                o.pe_row = 3'(r);
                                o.pe_column = 3'(c);
                                o.acc_value = acc[r][c];
                                o.quantized = quant(acc[r][c], t.shift_amount);
                                o.slot_word = {{8{o.quantized[7]}}, o.quantized};
                                o.last = (r == rows_act - 1) && (c == cols_act - 1);
                                pending = {pending, o};
                            end
                    end
                end
            endcase
        endfunction

        function void check_result(imaq_pkg::out_t got);
            imaq_pkg::out_t exp_r;
            if (pending.size() == 0)
            begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.status !== exp_r.status)
            begin
                $error("status exp %0d got %0d", exp_r.status, got.status);
                errors++;
            end
            if (got.pe_row !== exp_r.pe_row)
            begin
                $error("pe_row exp %0d got %0d", exp_r.pe_row, got.pe_row);
                errors++;
            end
            if (got.pe_column !== exp_r.pe_column)
            begin
                $error("pe_column exp %0d got %0d", exp_r.pe_column, got.pe_column);
                errors++;
            end
            if (got.acc_value !== exp_r.acc_value)
            begin
                $error("acc_value exp %0d got %0d", exp_r.acc_value, got.acc_value);
                errors++;
            end
            if (got.quantized !== exp_r.quantized)
            begin
                $error("quantized exp %0d got %0d", exp_r.quantized, got.quantized);
                errors++;
            end
            if (got.slot_word !== exp_r.slot_word)
            begin
                $error("slot_word exp %h got %h", exp_r.slot_word, got.slot_word);
                errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last exp %0d got %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    imaq_pkg::in_t  cmd;
    logic res_valid;
    logic res_stall;
    imaq_pkg::out_t res;

    mac_array_scoreboard board;
    bit quiet_stretch;
    int idle_cycles;

    int8_mac_array_accumulate_quantize_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd(cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic bit take_gap();
        return !quiet_stretch && ($urandom_range(99) < 29);
    endfunction

    // result side: random stall, checks on each transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall) board.check_result(res);
            res_stall <= take_gap();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // valid stays up after the transfer; the next call drops it or puts the next item on, the drain drops it
    task automatic send(imaq_pkg::in_t t);
        while (take_gap())
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= t;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        board.note_command(t);
    endtask

    function automatic imaq_pkg::in_t noise_item();
        logic [191:0] raw;
        imaq_pkg::in_t t;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        t = raw[$bits(imaq_pkg::in_t)-1:0];
        return t;
    endfunction

    function automatic imaq_pkg::in_t start_item(int nr, int nc);
        imaq_pkg::in_t t;
        t = noise_item();
        t.mode = imaq_pkg::MODE_START;
        t.rows_in_use = 4'(nr);
        t.columns_in_use = 4'(nc);
        return t;
    endfunction

    function automatic imaq_pkg::in_t mac_item(logic [63:0] a, logic [63:0] w);
        imaq_pkg::in_t t;
        t = noise_item();
        t.mode = imaq_pkg::MODE_MAC;
        t.activation_lanes = a;
        t.weight_lanes = w;
        return t;
    endfunction

    function automatic imaq_pkg::in_t bias_item(int col, int val, bit fin);
        imaq_pkg::in_t t;
        t = noise_item();
        t.mode = imaq_pkg::MODE_BIAS;
        t.bias_column = 3'(col);
        t.bias_value = 24'(val);
        t.bias_final = fin;
        return t;
    endfunction

    function automatic imaq_pkg::in_t read_item(int sh);
        imaq_pkg::in_t t;
        t = noise_item();
        t.mode = imaq_pkg::MODE_READ;
        t.shift_amount = 5'(sh);
        return t;
    endfunction

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int nr, nc, n_mac, sel;
        board = new();
        quiet_stretch = 0;
        rst_n = 0;
        cmd_valid = 0;
        cmd = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: phase errors from empty, bad sizes, bias before MAC, saturation, shifts
        send(read_item(0));
        send(mac_item('1, '1));
        send(bias_item(0, 5, 1));
        send(start_item(0, 3));
        send(start_item(9, 3));
        send(start_item(3, 15));
        send(start_item(8, 8));
        send(bias_item(0, 1, 0));
        send(read_item(0));
        send(mac_item({8{8'h80}}, {8{8'h80}}));
        for (int i = 0; i < 9; i++) send(mac_item({8{8'h80}}, {8{8'h80}}));
        send(bias_item(0, 24'sh7fffff, 0));
        send(mac_item({8{8'h80}}, {8{8'h7f}}));
        send(bias_item(1, -24'sh800000, 0));
        send(bias_item(7, -24'sh800000, 1));
        send(mac_item('1, '1));
        send(read_item(0));
        send(read_item(23));
        send(read_item(31));
        send(start_item(2, 1));
        send(mac_item(64'h0000_0000_0000_7f80, 64'h0000_0000_0000_0081));
        send(bias_item(1, 7, 1));
        send(bias_item(0, -3, 1));
        send(read_item(4));
        wait_drained();

        for (int k = 0; k < 18; k++)
        begin
            quiet_stretch = (k >= 8 && k < 12);
            nr = ($urandom_range(3) == 0) ? 8 : $urandom_range(1, 4);
            nc = ($urandom_range(3) == 0) ? 8 : $urandom_range(1, 4);
            if ($urandom_range(5) == 0) send(noise_item());
            send(start_item(nr, nc));
            n_mac = $urandom_range(1, 4);
            for (int i = 0; i < n_mac; i++)
                send(mac_item({$urandom, $urandom}, {$urandom, $urandom}));
            for (int i = 0; i < 2; i++)
            begin
                sel = $urandom_range(3);
                send(bias_item($urandom_range(7),
                               sel == 0 ? int'($urandom_range(255)) - 128 :
                               int'({$urandom} % 16777216) - 8388608, 0));
            end
            send(bias_item($urandom_range(nc - 1), int'($urandom_range(2000)) - 1000, 1));
            send(read_item($urandom_range(31)));
            if (k % 6 == 5) wait_drained();
        end
        quiet_stretch = 0;
        wait_drained();
        repeat (20) @(posedge clk);
        if (board.errors == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end
endmodule
